### design/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg: shared types and constants of the cross median filter
// Pixel and dimension types, the line-pair word held in the line memory,
// register indexes and the dimension clamp used by the configuration port.
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [DIM_W-1:0] dim_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam dim_t RESET_WIDTH  = 11'd640;
  localparam dim_t RESET_HEIGHT = 11'd480;

  // border that passes through unfiltered, and smallest region that filters
  localparam int unsigned MARGIN  = 2;
  localparam int unsigned MIN_DIM = 5;

  // one entry of the line memory: row two above and row just above
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  // map a written dimension into 1 .. maxv
  function automatic dim_t clamp_dim(dim_t v, int unsigned maxv);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (32'(v) > maxv) begin
      r = dim_t'(maxv);
    end
    return r;
  endfunction

endpackage

### design/cmf_line_mem.sv
// ----------------------------------------------------------------------------
// cmf_line_mem: line memory holding two rows per column
// One write and one read port, registered read data, write-first bypass
// when both ports address the same entry in one cycle.
// ----------------------------------------------------------------------------
module cmf_line_mem
  import cmf_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  line_pair_t    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output line_pair_t    rdata_o
);

  line_pair_t mem_q [DEPTH];
  line_pair_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, forward the word being written to the same entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/cmf_median5.sv
// ----------------------------------------------------------------------------
// cmf_median5: median of five pixels
// Ranks every input against the others in parallel (ties broken by input
// position) and selects the input of rank two.
// ----------------------------------------------------------------------------
module cmf_median5
  import cmf_pkg::*;
(
  input  pix_t a_i,
  input  pix_t b_i,
  input  pix_t c_i,
  input  pix_t d_i,
  input  pix_t e_i,
  output pix_t med_o
);

  pix_t       v [5];
  logic [2:0] rank [5];

  assign v[0] = a_i;
  assign v[1] = b_i;
  assign v[2] = c_i;
  assign v[3] = d_i;
  assign v[4] = e_i;

  // count smaller inputs, and equal ones at a lower position
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 5; j++) begin
        if ((v[j] < v[i]) || ((j < i) && (v[j] == v[i]))) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
    end
  end

  // pick the middle rank; ranks form a permutation so exactly one matches
  always_comb begin
    med_o = v[0];
    for (int i = 0; i < 5; i++) begin
      if (rank[i] == 3'd2) begin
        med_o = v[i];
      end
    end
  end

endmodule

### design/cross_median_filter_unit.sv
// ----------------------------------------------------------------------------
// cross_median_filter_unit: five-point cross median filter, raster stream
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  pixel_in_i, flush_i
//   out      output     out_valid_o / out_stall_i pixel_out_o, end_of_frame_o
//   cfg      input      cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// One item per clock unless stalled. Results pass the median stage and the
// output register; the filtered pixel trails its input by one row. Both lines
// live in one memory word per column, read one column ahead, so the line
// memory port sets the rate. Reset restores the dimensions, clears counters
// and handshake state; the line memory is not cleared. A stalled output holds
// the median stage, which then stalls the input in the same cycle.
// ----------------------------------------------------------------------------
module cross_median_filter_unit
  import cmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  dim_t                 cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_t                 pixel_in_i,
  input  logic                 flush_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pix_t                 pixel_out_o,
  output logic                 end_of_frame_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MW  = (CW > RW) ? CW : RW;
  localparam int unsigned XW  = ((MW > DIM_W) ? MW : DIM_W) + 2;

  // configuration and position
  dim_t          width_q, height_q;
  logic [CW-1:0] col_q, next_col;
  logic [RW-1:0] row_q;
  pix_t          left_q;

  // compare-width views
  logic [XW-1:0] col_x, row_x, w_x, h_x;
  logic          draining, last_col, in_margin;
  logic          in_accept, take_pix, take_drain;

  // line memory
  line_pair_t    mem_wdata, mem_rdata;
  logic          mem_we, mem_re;

  // median stage
  logic          s2_valid_q, s2_med_q, s2_eof_q;
  pix_t          s2_centre_q, s2_left_q, s2_up_q, s2_pix_q;
  pix_t          med_val, s2_result;
  logic          s2_adv;

  // output register
  logic          out_valid_q, out_eof_q, out_free;
  pix_t          out_pix_q;

  assign col_x = XW'(col_q);
  assign row_x = XW'(row_q);
  assign w_x   = XW'(width_q);
  assign h_x   = XW'(height_q);

  // decode the current position
  assign draining  = row_x >= h_x;
  assign last_col  = (col_x + XW'(1)) == w_x;
  assign next_col  = last_col ? '0 : col_q + CW'(1);
  assign in_margin = (w_x >= XW'(MIN_DIM)) && (h_x >= XW'(MIN_DIM)) &&
                     (col_x >= XW'(MARGIN)) && ((col_x + XW'(MARGIN)) < w_x) &&
                     (row_x >= XW'(MARGIN + 1)) && ((row_x - XW'(1)) + XW'(MARGIN) < h_x);

  // handshake: the median stage holds only while the output is blocked
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign in_stall_o = s2_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign take_drain = in_accept && draining;
  assign take_pix   = in_accept && !draining && !flush_i;

  // shift lines at the current column, prefetch the next column
  assign mem_we    = take_pix;
  assign mem_re    = take_pix || take_drain;
  assign mem_wdata = '{upper: mem_rdata.middle, middle: pixel_in_i};

  cmf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (col_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (next_col),
    .rdata_o (mem_rdata)
  );

  // configuration and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= clamp_dim(cfg_wdata_i, MAX_WIDTH);
        CFG_FRAME_HEIGHT: height_q <= clamp_dim(cfg_wdata_i, MAX_HEIGHT);
        default:          width_q  <= width_q;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (take_drain) begin
      col_q <= next_col;
      if (last_col) begin
        row_q <= '0;
      end
    end else if (take_pix) begin
      col_q <= next_col;
      if (last_col) begin
        row_q <= row_q + RW'(1);
      end
    end
  end

  // hold the centre of the previous column as the left neighbor
  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      left_q <= mem_rdata.middle;
    end
  end

  // median stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_accept) begin
      s2_valid_q <= take_drain || (take_pix && (row_q != '0));
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  // capture the window; the right neighbor arrives from memory next cycle
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s2_centre_q <= mem_rdata.middle;
      s2_up_q     <= mem_rdata.upper;
      s2_left_q   <= left_q;
      s2_pix_q    <= pixel_in_i;
      s2_med_q    <= take_pix && in_margin;
      s2_eof_q    <= take_drain && last_col;
    end
  end

  cmf_median5 u_median5 (
    .a_i   (s2_centre_q),
    .b_i   (s2_left_q),
    .c_i   (mem_rdata.middle),
    .d_i   (s2_up_q),
    .e_i   (s2_pix_q),
    .med_o (med_val)
  );

  assign s2_result = s2_med_q ? med_val : s2_centre_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_pix_q <= s2_result;
      out_eof_q <= s2_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign end_of_frame_o = out_eof_q;

endmodule

### sim/tb_cross_median_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_cross_median_filter_unit: self-checking bench for the cross median filter
// Streams regions of gray pixels through the filter under random sender gaps
// and receiver stalls, predicts every filtered pixel and end-of-frame flag
// with a cycle-free model of the five-point cross median, and compares each
// output transfer in order. Covers reset dimensions, clamped register writes,
// one-row and one-column regions, ignored flushes, pixels during the drain and
// register writes in the middle of a region.
// ----------------------------------------------------------------------------
module tb_cross_median_filter_unit
  import cmf_pkg::*;
();

  localparam int unsigned LINE_MAX      = 1024;
  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned LONG_HOLD     = 400;

  typedef struct packed {
    pix_t value;
    logic last;
  } filt_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the filter state and queues the expected output pixels
  // --------------------------------------------------------------------------
  class cmf_scoreboard;
    int unsigned  width_px;
    int unsigned  height_px;
    pix_t         row_above2 [LINE_MAX];
    pix_t         row_above1 [LINE_MAX];
    pix_t         prev_centre;
    int unsigned  col;
    int unsigned  row;
    int unsigned  emitted;
    filt_result_t pending_pixels [$];
    int unsigned  errors;

    function new();
      width_px    = RESET_WIDTH;
      height_px   = RESET_HEIGHT;
      prev_centre = '0;
      errors      = 0;
      foreach (row_above2[i]) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      col     = 0;
      row     = 0;
      emitted = 0;
    endfunction

    // median of five through rank counting
    function pix_t cross_median(pix_t a, pix_t b, pix_t c, pix_t d, pix_t e);
      pix_t        v [5];
      int unsigned lt;
      int unsigned le;
      v = '{a, b, c, d, e};
      for (int i = 0; i < 5; i++) begin
        lt = 0;
        le = 0;
        for (int j = 0; j < 5; j++) begin
          if (v[j] < v[i]) lt++;
          if (v[j] <= v[i]) le++;
        end
        if (lt <= 2 && le >= 3) return v[i];
      end
      return v[0];
    endfunction

    // clamp a written dimension into 1 .. LINE_MAX and start a new region
    function void write_reg(logic [CFG_IDX_W-1:0] idx, dim_t val);
      int unsigned v;
      v = val;
      if (v == 0) v = 1;
      else if (v > LINE_MAX) v = LINE_MAX;
      if (idx == CFG_FRAME_WIDTH) width_px = v;
      else height_px = v;
      restart();
    endfunction

    function void push_result(pix_t value);
      filt_result_t r;
      r.value = value;
      r.last  = ((emitted + 1) == width_px * height_px);
      pending_pixels.insert(pending_pixels.size(), r);
      emitted = (emitted + 1) & 32'h000F_FFFF;
    endfunction

    // advance the model by one accepted input transfer
    function void note_input(pix_t px, logic flush);
      int unsigned c;
      int unsigned orow;
      pix_t        centre;
      pix_t        right;
      pix_t        left;
      pix_t        res;
      c = (col >= width_px) ? 0 : col;

      // drain the last row: margin only, pass through
      if (row >= height_px) begin
        push_result(row_above1[c]);
        c++;
        if (c >= width_px) restart();
        else col = c;
        return;
      end

      // drop a flush inside the region
      if (flush) return;

      centre      = row_above1[c];
      right       = (c + 1 < width_px) ? row_above1[c + 1] : '0;
      left        = prev_centre;
      prev_centre = centre;

      if (row >= 1) begin
        orow = row - 1;
        res  = centre;
        if (width_px >= MIN_DIM && height_px >= MIN_DIM &&
            c >= MARGIN && c + MARGIN < width_px &&
            orow >= MARGIN && orow + MARGIN < height_px) begin
          res = cross_median(centre, left, right, row_above2[c], px);
        end
        push_result(res);
      end

      row_above2[c] = centre;
      row_above1[c] = px;
      c++;
      if (c >= width_px) begin
        col = 0;
        row++;
      end else begin
        col = c;
      end
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_result(pix_t px, logic last);
      filt_result_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: pixel_out=%0d end_of_frame=%0b", px, last);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (px !== want.value) begin
        $error("pixel_out: expected %0d, actual %0d", want.value, px);
        errors++;
      end
      if (last !== want.last) begin
        $error("end_of_frame: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  dim_t                 cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  pix_t                 pixel_in_i;
  logic                 flush_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  pix_t                 pixel_out_o;
  logic                 end_of_frame_o;

  cmf_scoreboard sb;
  int unsigned   burst_left;
  int unsigned   stream_items;
  bit            hold_req;
  pix_t          probe_frame [25];

  cross_median_filter_unit #(
    .MAX_WIDTH (LINE_MAX),
    .MAX_HEIGHT(LINE_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_in_i    (pixel_in_i),
    .flush_i       (flush_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_out_o   (pixel_out_o),
    .end_of_frame_o(end_of_frame_o)
  );

  // 10-unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // track register writes and both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.note_input(pixel_in_i, flush_i);
      if (out_valid_o && !out_stall_i) sb.check_result(pixel_out_o, end_of_frame_o);
    end
  end

  // receiver stalls: random segments, plus one long hold on request
  initial begin : stall_gen
    int unsigned mode;
    int unsigned seg_len;
    int unsigned hold_cnt;
    bit          hold_taken;
    out_stall_i = 1'b0;
    hold_cnt    = 0;
    hold_taken  = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 150);
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk_i);
        if (hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          hold_cnt   = LONG_HOLD;
        end
        if (hold_cnt > 0) begin
          out_stall_i <= 1'b1;
          hold_cnt--;
        end else begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 99) < 30);
            2:       out_stall_i <= ($urandom_range(0, 99) < 70);
            default: out_stall_i <= k[2];
          endcase
        end
      end
    end
  end

  // hard stop for a hung run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // mix of random, near-tie and extreme gray values
  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 3))
      0, 1:    return pix_t'($urandom_range(0, 255));
      2:       return pix_t'($urandom_range(0, 3));
      default: return ($urandom_range(0, 1) != 0) ? pix_t'(8'hFC | $urandom_range(0, 3))
                                                   : 8'h00;
    endcase
  endfunction

  // offer one item, in bursts with random gaps, and hold it until the transfer
  task automatic send_item(input pix_t px, input logic fl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    flush_i    <= fl;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    burst_left--;
  endtask

  // drop valid and wait until every expected pixel has left the block
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input dim_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_frame(input dim_t w, input dim_t h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_FRAME_HEIGHT;
    cfg_wdata_i <= h;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // stream one region with stray flushes, then drain its last row;
  // optionally cut it short, which leaves the block in the middle of a region
  task automatic run_frame(input int unsigned w, input int unsigned h,
                           input bit may_cut, output bit cut);
    int unsigned n_pix;
    int unsigned stop_at;
    n_pix   = w * h;
    stop_at = n_pix;
    if (may_cut && $urandom_range(0, 9) == 0) stop_at = $urandom_range(1, n_pix - 1 + 1);
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(pick_pixel(), 1'b1);
      send_item(pick_pixel(), 1'b0);
      stream_items++;
    end
    cut = (stop_at != n_pix);
    if (!cut) begin
      for (int i = 0; i < w; i++) begin
        send_item(pick_pixel(), ($urandom_range(0, 3) != 0));
        stream_items++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned cur_w;
    int unsigned cur_h;
    bit          cut;
    bit          need_cfg;

    sb           = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_FRAME_WIDTH;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    pixel_in_i   = '0;
    flush_i      = 1'b0;
    burst_left   = 0;
    stream_items = 0;
    hold_req     = 1'b0;
    probe_frame  = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
                     8'h80, 8'h7F, 8'hFF, 8'h00, 8'hFE,
                     8'h10, 8'h20, 8'h30, 8'h40, 8'h50,
                     8'hFF, 8'h00, 8'h00, 8'h11, 8'h22,
                     8'h33, 8'h44, 8'h55, 8'h66, 8'h77};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset dimensions: first row silent, then pass-through of row 0
    repeat (int'(RESET_WIDTH) + 8) send_item(pick_pixel(), 1'b0);
    wait_drained();

    // smallest filtering region, with a stray flush and pixels in the drain
    set_frame(11'd5, 11'd5);
    for (int i = 0; i < 25; i++) begin
      if (i == 7) send_item(8'hFF, 1'b1);
      send_item(probe_frame[i], 1'b0);
    end
    send_item(8'hFF, 1'b1);
    send_item(8'h5A, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // back-to-back region without a register write
    run_frame(5, 5, 1'b0, cut);
    wait_drained();

    // zero width clamps to one, all-ones height clamps to the maximum,
    // so a short column passes through with no early drain
    write_one(CFG_FRAME_WIDTH, '0);
    write_one(CFG_FRAME_HEIGHT, '1);
    repeat (20) send_item(pick_pixel(), 1'b0);
    wait_drained();

    // zero height clamps to one: every pixel leaves during the drain
    set_frame(11'd12, '0);
    run_frame(12, 1, 1'b0, cut);
    wait_drained();

    // register write in the middle of a region restarts it
    set_frame(11'd6, 11'd7);
    repeat (15) send_item(pick_pixel(), 1'b0);
    wait_drained();
    write_one(CFG_FRAME_HEIGHT, 11'd7);
    run_frame(6, 7, 1'b0, cut);
    wait_drained();

    // narrow region passes through; receiver holds off once to back up the input
    set_frame(11'd4, 11'd6);
    hold_req = 1'b1;
    run_frame(4, 6, 1'b0, cut);

    // random regions
    stream_items = 0;
    cur_w        = 4;
    cur_h        = 6;
    need_cfg     = 1'b0;
    while (stream_items < RANDOM_ITEMS) begin
      if (need_cfg || $urandom_range(0, 2) != 0) begin
        wait_drained();
        case ($urandom_range(0, 3))
          0: begin
            cur_w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            write_one(CFG_FRAME_WIDTH, dim_t'(cur_w));
          end
          1: begin
            cur_h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
            write_one(CFG_FRAME_HEIGHT, dim_t'(cur_h));
          end
          default: begin
            cur_w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            cur_h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
            set_frame(dim_t'(cur_w), dim_t'(cur_h));
          end
        endcase
      end
      run_frame(cur_w, cur_h, 1'b1, cut);
      need_cfg = cut;
    end

    // wait out the last results, then watch for strays
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
